// ----- src/aes_rnd_pkg.sv -----
// Shared types, S-box table and GF(2^8) helpers for the AES round core.
package aes_rnd_pkg;

  localparam int BlockW = 128;
  localparam int HalfW  = 64;
  localparam int NumCols = 4;
  localparam int NumRows = 4;
  localparam logic [7:0] GfPoly = 8'h1b;

  typedef logic [7:0] byte_t;
  typedef byte_t [NumRows-1:0] col_t;
  typedef col_t [NumCols-1:0] blk_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t xtime(input byte_t b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? GfPoly : 8'h00);
  endfunction

endpackage

// ----- src/aes_rnd_lane.sv -----
// One column lane: SubBytes on the shifted column, MixColumns, round key add.
module aes_rnd_lane (
  input  aes_rnd_pkg::col_t col_i,
  input  aes_rnd_pkg::col_t key_i,
  output aes_rnd_pkg::col_t col_o
);

  aes_rnd_pkg::col_t a;
  aes_rnd_pkg::col_t d;

  always_comb begin
    for (int r = 0; r < aes_rnd_pkg::NumRows; r++) begin
      a[r] = aes_rnd_pkg::SBOX[col_i[r]];
      d[r] = aes_rnd_pkg::xtime(a[r]);
    end
    col_o[0] = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3] ^ key_i[0];
    col_o[1] = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3] ^ key_i[1];
    col_o[2] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3] ^ key_i[2];
    col_o[3] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3] ^ key_i[3];
  end

endmodule

// ----- src/aes_rnd_merge.sv -----
// Merge stage: packs the lane columns into the output register.
module aes_rnd_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  aes_rnd_pkg::blk_t                  cols_i,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [aes_rnd_pkg::BlockW-1:0]     out_tdata
);

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [aes_rnd_pkg::BlockW-1:0]    res_r;
  logic [aes_rnd_pkg::BlockW-1:0]    res_nxt;
  logic                              load;

  assign ready_o = !out_valid_r || out_tready;
  assign load    = valid_i && ready_o;

  always_comb begin
    // byte 4c+r sits at bits 127-8(4c+r)
    for (int c = 0; c < aes_rnd_pkg::NumCols; c++) begin
      for (int r = 0; r < aes_rnd_pkg::NumRows; r++) begin
        res_nxt[aes_rnd_pkg::BlockW-1-8*(4*c+r) -: 8] = cols_i[c][r];
      end
    end
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  // out_hi in the low half, out_lo in the high half
  assign out_tdata  = {res_r[aes_rnd_pkg::HalfW-1:0],
                       res_r[aes_rnd_pkg::BlockW-1:aes_rnd_pkg::HalfW]};

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded transaction not presented");

  a_stall_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !load)
    else $error("output register overwritten while stalled");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !valid_i) |=> !out_valid_r)
    else $error("transaction delivered twice");

endmodule

// ----- src/aes_encrypt_round_core.sv -----
// Top level of the AES-128 middle encryption round: input register, column lanes, merge.
// A transaction passes the input register, then the output register, before result valid.
// Throughput: one block per cycle while out_tready stays high; four column lanes compute the round in parallel.
// The input stage takes a new transaction while a result waits, until both stages are full.
// Reset (rst_n low, synchronous) clears the stage valid flags; data registers are not reset.
module aes_encrypt_round_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // block_hi [63:0], block_lo [127:64], round_key_hi [191:128], round_key_lo [255:192]
  input  logic [255:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // out_hi [63:0], out_lo [127:64]
  output logic [127:0]  out_tdata
);

  localparam int HW = aes_rnd_pkg::HalfW;

  logic                              s1_valid_r;
  logic                              s1_valid_nxt;
  logic [aes_rnd_pkg::BlockW-1:0]    s1_state_r;
  logic [aes_rnd_pkg::BlockW-1:0]    s1_key_r;
  logic                              merge_rdy;
  logic                              in_acc;
  aes_rnd_pkg::blk_t                 lane_in;
  aes_rnd_pkg::blk_t                 lane_key;
  aes_rnd_pkg::blk_t                 lane_out;

  assign in_tready = !s1_valid_r || merge_rdy;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (merge_rdy ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_state_r <= {in_tdata[HW-1:0], in_tdata[2*HW-1:HW]};
      s1_key_r   <= {in_tdata[3*HW-1:2*HW], in_tdata[4*HW-1:3*HW]};
    end
  end

  // ShiftRows routing: row r of column c takes byte r + 4((c+r) mod 4)
  for (genvar c = 0; c < aes_rnd_pkg::NumCols; c++) begin : g_col
    for (genvar r = 0; r < aes_rnd_pkg::NumRows; r++) begin : g_row
      localparam int SrcIdx = r + 4 * ((c + r) % 4);
      localparam int KeyIdx = 4 * c + r;
      assign lane_in[c][r]  = s1_state_r[aes_rnd_pkg::BlockW-1-8*SrcIdx -: 8];
      assign lane_key[c][r] = s1_key_r[aes_rnd_pkg::BlockW-1-8*KeyIdx -: 8];
    end
    aes_rnd_lane u_lane (
      .col_i (lane_in[c]),
      .key_i (lane_key[c]),
      .col_o (lane_out[c])
    );
  end

  aes_rnd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (s1_valid_r),
    .ready_o    (merge_rdy),
    .cols_i     (lane_out),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && merge_rdy) |=> out_tvalid)
    else $error("stage one transaction lost");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted with both stages full");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction not held");

endmodule

// ----- tb/aes_round_checker.sv -----
// Checker for the AES round core: predicts each round output, compares with the result channel.
module aes_round_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [255:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  output int           errors,
  output int           outstanding
);

  localparam logic [8:0]         AesPoly = 9'h11b;
  localparam aes_rnd_pkg::byte_t AffineC = 8'h63;

  aes_rnd_pkg::byte_t               sub_tab [256];
  logic [2*aes_rnd_pkg::HalfW-1:0]  round_due [$];
  int                               err_cnt = 0;

  function automatic aes_rnd_pkg::byte_t gf_dbl(input aes_rnd_pkg::byte_t b);
    logic [8:0] t;
    t = {b, 1'b0};
    if (t[8]) t = t ^ AesPoly;
    return t[7:0];
  endfunction

  function automatic aes_rnd_pkg::byte_t gf_mul(input aes_rnd_pkg::byte_t a,
                                                input aes_rnd_pkg::byte_t b);
    aes_rnd_pkg::byte_t acc;
    aes_rnd_pkg::byte_t p;
    acc = '0;
    p   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ p;
      p = gf_dbl(p);
    end
    return acc;
  endfunction

  function automatic aes_rnd_pkg::byte_t rotl8(input aes_rnd_pkg::byte_t x, input int n);
    return aes_rnd_pkg::byte_t'((x << n) | (x >> (8 - n)));
  endfunction

  // S-box built from the field inverse and the affine map
  initial begin
    aes_rnd_pkg::byte_t inv;
    for (int a = 0; a < 256; a++) begin
      inv = '0;
      for (int c = 1; c < 256; c++) begin
        if (gf_mul(aes_rnd_pkg::byte_t'(a), aes_rnd_pkg::byte_t'(c)) == 8'h01) begin
          inv = aes_rnd_pkg::byte_t'(c);
        end
      end
      sub_tab[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ AffineC;
    end
  end

  // result: out_hi in [63:0], out_lo in [127:64]
  function automatic logic [127:0] aes_mid_round(input logic [255:0] d);
    aes_rnd_pkg::byte_t st [16];
    aes_rnd_pkg::byte_t rk [16];
    aes_rnd_pkg::byte_t sh [16];
    aes_rnd_pkg::byte_t mx [16];
    aes_rnd_pkg::byte_t a0, a1, a2, a3;
    logic [127:0]       res;
    for (int k = 0; k < 8; k++) begin
      st[k]     = d[63 - 8*k -: 8];
      st[k + 8] = d[127 - 8*k -: 8];
      rk[k]     = d[191 - 8*k -: 8];
      rk[k + 8] = d[255 - 8*k -: 8];
    end
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        sh[row + 4*col] = sub_tab[st[row + 4*((col + row) % 4)]];
      end
    end
    for (int col = 0; col < 4; col++) begin
      a0 = sh[4*col];
      a1 = sh[4*col + 1];
      a2 = sh[4*col + 2];
      a3 = sh[4*col + 3];
      mx[4*col]     = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3 ^ rk[4*col];
      mx[4*col + 1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3 ^ rk[4*col + 1];
      mx[4*col + 2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03) ^ rk[4*col + 2];
      mx[4*col + 3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02) ^ rk[4*col + 3];
    end
    for (int k = 0; k < 8; k++) begin
      res[63 - 8*k -: 8]  = mx[k];
      res[127 - 8*k -: 8] = mx[k + 8];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst_n) begin
      round_due.delete();
    end else begin
      if (in_tvalid && in_tready) round_due.push_back(aes_mid_round(in_tdata));
      if (out_tvalid && out_tready) begin
        if (round_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result transaction, got %h", $time, out_tdata);
        end else begin
          want = round_due.pop_front();
          if (out_tdata[63:0] !== want[63:0]) begin
            err_cnt++;
            $display("%0t: out_hi mismatch, expected %h, got %h",
                     $time, want[63:0], out_tdata[63:0]);
          end
          if (out_tdata[127:64] !== want[127:64]) begin
            err_cnt++;
            $display("%0t: out_lo mismatch, expected %h, got %h",
                     $time, want[127:64], out_tdata[127:64]);
          end
        end
      end
    end
    errors      <= err_cnt;
    outstanding <= round_due.size();
  end

endmodule

// ----- tb/tb_aes_encrypt_round_core.sv -----
// Testbench top for the AES round core: drives blocks, throttles the result side, verdict.
module tb_aes_encrypt_round_core;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  int           errors;
  int           outstanding;
  bit           src_gaps;
  bit           sink_stalls;
  bit           sink_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL aes_encrypt_round_core");
    $finish;
  end

  aes_encrypt_round_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  aes_round_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_block(input logic [255:0] d);
    while (src_gaps && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [255:0] rand_block();
    logic [255:0] d;
    for (int k = 0; k < 8; k++) d[32*k +: 32] = $urandom;
    return d;
  endfunction

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        sink_hold = 1'b0;
        out_tready <= 1'b0;
        for (int hold = 0; hold < 400; hold++) @(negedge clk);
      end
      out_tready <= !(sink_stalls && $urandom_range(99) < 28);
    end
  end

  initial begin
    logic [255:0] d;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    sink_hold   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_block('0);
    send_block('1);
    send_block({{128{1'b1}}, 128'h0});
    send_block({128'h0, {128{1'b1}}});
    send_block({32{8'h80}});
    send_block({{16{8'h55}}, {16{8'haa}}});
    // every byte value once through the block, sixteen values per S-box lane
    for (int n = 0; n < 16; n++) begin
      for (int k = 0; k < 16; k++) begin
        d[8*k +: 8]       = 8'(16*n + k);
        d[128 + 8*k +: 8] = 8'(255 - 16*n - k);
      end
      send_block(d);
    end

    repeat (600) send_block(rand_block());

    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    repeat (300) send_block(rand_block());

    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    sink_hold   = 1'b1;
    repeat (600) send_block(rand_block());

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS aes_encrypt_round_core");
    end else begin
      $display("FAIL aes_encrypt_round_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/aes_rnd_pkg.sv
src/aes_rnd_lane.sv
src/aes_rnd_merge.sv
src/aes_encrypt_round_core.sv
tb/aes_round_checker.sv
tb/tb_aes_encrypt_round_core.sv
